// ===== design/bcn_texture_block_decoder_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros used by the checker file of the texture block decoder.
// ----------------------------------------------------------------------------
`ifndef BCN_TEXTURE_BLOCK_DECODER_ASSERT_SVH
`define BCN_TEXTURE_BLOCK_DECODER_ASSERT_SVH

// Concurrent assertion that is switched off while reset is high.
`define BCN_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that is also checked while reset is high.
`define BCN_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/bcn_pkg.sv =====
// ----------------------------------------------------------------------------
// bcn_pkg
// Types and constants shared by the stages of the BCn texture block decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bcn_pkg;

   typedef enum logic [2:0] {
      FMT_BC1 = 3'd0,
      FMT_BC2 = 3'd1,
      FMT_BC3 = 3'd2,
      FMT_BC4 = 3'd3,
      FMT_BC5 = 3'd4
   } fmt_type;

   // Division by a constant is done as a multiply by ceil(2^SHIFT / D).
   // With numerators below 2^16 (colour) or 2^11 (interpolated alpha) the
   // product shifted down is the exact floor of the quotient.
   localparam int unsigned COLOR_SHIFT  = 24;
   localparam int unsigned INTERP_SHIFT = 16;

   localparam int unsigned RECIP_31  = ((1 << COLOR_SHIFT) + 31 - 1) / 31;
   localparam int unsigned RECIP_63  = ((1 << COLOR_SHIFT) + 63 - 1) / 63;
   localparam int unsigned RECIP_62  = ((1 << COLOR_SHIFT) + 62 - 1) / 62;
   localparam int unsigned RECIP_126 = ((1 << COLOR_SHIFT) + 126 - 1) / 126;
   localparam int unsigned RECIP_93  = ((1 << COLOR_SHIFT) + 93 - 1) / 93;
   localparam int unsigned RECIP_189 = ((1 << COLOR_SHIFT) + 189 - 1) / 189;
   localparam int unsigned RECIP_7   = ((1 << INTERP_SHIFT) + 7 - 1) / 7;
   localparam int unsigned RECIP_5   = ((1 << INTERP_SHIFT) + 5 - 1) / 5;

   localparam int unsigned CNUM_W  = 16;
   localparam int unsigned CMUL_W  = 20;
   localparam int unsigned CPROD_W = CNUM_W + CMUL_W;
   localparam int unsigned INUM_W  = 11;
   localparam int unsigned IMUL_W  = 14;
   localparam int unsigned IPROD_W = INUM_W + IMUL_W;

   typedef struct packed {
      fmt_type     fmt;
      logic [63:0] cb;
      logic [63:0] ab;
   } blk_type;

   typedef struct packed {
      logic [CNUM_W-1:0] num;
      logic [CMUL_W-1:0] mul;
   } cdiv_type;

   typedef struct packed {
      logic [INUM_W-1:0] num;
      logic [IMUL_W-1:0] mul;
   } idiv_type;

   typedef struct packed {
      logic [7:0]         a0;
      logic [7:0]         a1;
      logic               mode7;
      idiv_type [5:0]     div;
   } inum_type;

   typedef struct packed {
      fmt_type              fmt;
      logic                 three;
      cdiv_type [3:0][2:0]  cdiv;
      inum_type             ip1;
      inum_type             ip2;
      logic [63:0]          cb;
      logic [63:0]          ab;
   } num_type;

   typedef struct packed {
      fmt_type               fmt;
      logic                  three;
      logic [3:0][2:0][7:0]  cpal;
      logic [7:0][7:0]       ipal1;
      logic [7:0][7:0]       ipal2;
      logic [63:0]           cb;
      logic [63:0]           ab;
   } pal_type;

endpackage

// ===== design/bcn_numer.sv =====
// ----------------------------------------------------------------------------
// bcn_numer
// Second pipeline stage: endpoint unpacking, palette numerators and the
// reciprocal that goes with each divisor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bcn_numer
   import bcn_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    load,
   input  logic    in_valid,
   input  blk_type in_data,
   output logic    out_valid,
   output num_type out_data
);

   logic    valid_ff, valid_in;
   num_type data_ff, data_in;

   function automatic inum_type interp_num(logic [15:0] ep);
      inum_type res;
      res.a0    = ep[7:0];
      res.a1    = ep[15:8];
      res.mode7 = (ep[7:0] > ep[15:8]);
      for (int j = 0; j < 6; j++) begin
         if (res.mode7) begin
            res.div[j].num = INUM_W'(6 - j) * INUM_W'(res.a0)
                           + INUM_W'(j + 1) * INUM_W'(res.a1);
            res.div[j].mul = IMUL_W'(RECIP_7);
         end else if (j < 4) begin
            res.div[j].num = INUM_W'(4 - j) * INUM_W'(res.a0)
                           + INUM_W'(j + 1) * INUM_W'(res.a1);
            res.div[j].mul = IMUL_W'(RECIP_5);
         end else begin
            // Entries six and seven are fixed in the five-step mode.
            res.div[j].num = '0;
            res.div[j].mul = '0;
         end
      end
      return res;
   endfunction

   always_comb begin
      logic [15:0]     c0, c1;
      logic [2:0][5:0] e0, e1;
      logic [7:0]      s2, s3;
      logic            three;
      c0 = in_data.cb[15:0];
      c1 = in_data.cb[31:16];
      three = (in_data.fmt == FMT_BC1) && (c0 <= c1);
      e0[0] = {1'b0, c0[15:11]};
      e0[1] = c0[10:5];
      e0[2] = {1'b0, c0[4:0]};
      e1[0] = {1'b0, c1[15:11]};
      e1[1] = c1[10:5];
      e1[2] = {1'b0, c1[4:0]};

      data_in.fmt   = in_data.fmt;
      data_in.three = three;
      data_in.cb    = in_data.cb;
      data_in.ab    = in_data.ab;
      data_in.ip1   = interp_num(in_data.cb[15:0]);
      data_in.ip2   = interp_num(in_data.ab[15:0]);

      for (int ch = 0; ch < 3; ch++) begin
         if (three) begin
            s2 = 8'(e0[ch]) + 8'(e1[ch]);
            s3 = '0;
         end else begin
            s2 = 8'(e0[ch]) + 8'(e0[ch]) + 8'(e1[ch]);
            s3 = 8'(e0[ch]) + 8'(e1[ch]) + 8'(e1[ch]);
         end
         data_in.cdiv[0][ch].num = CNUM_W'(e0[ch]) * CNUM_W'(255);
         data_in.cdiv[1][ch].num = CNUM_W'(e1[ch]) * CNUM_W'(255);
         data_in.cdiv[2][ch].num = CNUM_W'(s2) * CNUM_W'(255);
         data_in.cdiv[3][ch].num = CNUM_W'(s3) * CNUM_W'(255);
         // Green has six bits, red and blue five.
         if (ch == 1) begin
            data_in.cdiv[0][ch].mul = CMUL_W'(RECIP_63);
            data_in.cdiv[1][ch].mul = CMUL_W'(RECIP_63);
            data_in.cdiv[2][ch].mul = three ? CMUL_W'(RECIP_126) : CMUL_W'(RECIP_189);
            data_in.cdiv[3][ch].mul = three ? CMUL_W'(RECIP_126) : CMUL_W'(RECIP_189);
         end else begin
            data_in.cdiv[0][ch].mul = CMUL_W'(RECIP_31);
            data_in.cdiv[1][ch].mul = CMUL_W'(RECIP_31);
            data_in.cdiv[2][ch].mul = three ? CMUL_W'(RECIP_62) : CMUL_W'(RECIP_93);
            data_in.cdiv[3][ch].mul = three ? CMUL_W'(RECIP_62) : CMUL_W'(RECIP_93);
         end
      end
   end

   assign valid_in = load ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== design/bcn_recip.sv =====
// ----------------------------------------------------------------------------
// bcn_recip
// Third pipeline stage: reciprocal multiplies that turn the numerators into
// the colour and interpolated palettes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bcn_recip
   import bcn_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    load,
   input  logic    in_valid,
   input  num_type in_data,
   output logic    out_valid,
   output pal_type out_data
);

   logic    valid_ff, valid_in;
   pal_type data_ff, data_in;

   always_comb begin
      logic [CPROD_W-1:0] cprod;
      logic [IPROD_W-1:0] iprod1, iprod2;
      data_in.fmt   = in_data.fmt;
      data_in.three = in_data.three;
      data_in.cb    = in_data.cb;
      data_in.ab    = in_data.ab;
      for (int e = 0; e < 4; e++) begin
         for (int ch = 0; ch < 3; ch++) begin
            cprod = CPROD_W'(in_data.cdiv[e][ch].num) * CPROD_W'(in_data.cdiv[e][ch].mul);
            data_in.cpal[e][ch] = cprod[COLOR_SHIFT +: 8];
         end
      end
      data_in.ipal1[0] = in_data.ip1.a0;
      data_in.ipal1[1] = in_data.ip1.a1;
      data_in.ipal2[0] = in_data.ip2.a0;
      data_in.ipal2[1] = in_data.ip2.a1;
      for (int j = 0; j < 6; j++) begin
         iprod1 = IPROD_W'(in_data.ip1.div[j].num) * IPROD_W'(in_data.ip1.div[j].mul);
         iprod2 = IPROD_W'(in_data.ip2.div[j].num) * IPROD_W'(in_data.ip2.div[j].mul);
         data_in.ipal1[j + 2] = iprod1[INTERP_SHIFT +: 8];
         data_in.ipal2[j + 2] = iprod2[INTERP_SHIFT +: 8];
      end
      // The five-step mode ends with full-scale white in the last entry.
      if (!in_data.ip1.mode7) begin
         data_in.ipal1[7] = 8'hFF;
      end
      if (!in_data.ip2.mode7) begin
         data_in.ipal2[7] = 8'hFF;
      end
   end

   assign valid_in = load ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== design/bcn_serial.sv =====
// ----------------------------------------------------------------------------
// bcn_serial
// Texel serializer: holds one decoded palette set and walks the sixteen
// texels into the result register, one per cycle unless it is stalled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bcn_serial
   import bcn_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  pal_type     in_data,
   output logic        take,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,
   output logic        rsp_tlast
);

   pal_type     blk_ff;
   logic        busy_ff, busy_in;
   logic [3:0]  count_ff, count_in;
   logic        out_valid_ff, out_valid_in;
   logic [39:0] out_data_ff;
   logic        out_last_ff;
   logic        out_load, fire;
   logic [7:0]  red, green, blue, alpha;

   assign out_load = !out_valid_ff || rsp_tready;
   assign fire     = busy_ff && out_load;
   assign take     = !busy_ff || (fire && (count_ff == 4'd15));

   always_comb begin
      logic [1:0] ci;
      logic [2:0] ii1, ii2;
      logic [3:0] a4;
      ci  = blk_ff.cb[{1'b1, count_ff, 1'b0} +: 2];
      ii1 = blk_ff.cb[6'd16 + {1'b0, count_ff, 1'b0} + {2'b00, count_ff} +: 3];
      ii2 = blk_ff.ab[6'd16 + {1'b0, count_ff, 1'b0} + {2'b00, count_ff} +: 3];
      a4  = blk_ff.ab[{count_ff, 2'b00} +: 4];
      red   = blk_ff.cpal[ci][0];
      green = blk_ff.cpal[ci][1];
      blue  = blk_ff.cpal[ci][2];
      alpha = 8'hFF;
      unique case (blk_ff.fmt)
         FMT_BC1: begin
            if (blk_ff.three && (ci == 2'd3)) begin
               alpha = 8'h00;
            end
         end
         FMT_BC2: begin
            alpha = {a4, a4};
         end
         FMT_BC3: begin
            alpha = blk_ff.ipal2[ii2];
         end
         FMT_BC4: begin
            red   = blk_ff.ipal1[ii1];
            green = blk_ff.ipal1[ii1];
            blue  = blk_ff.ipal1[ii1];
            alpha = blk_ff.ipal1[ii1];
         end
         FMT_BC5: begin
            red   = blk_ff.ipal1[ii1];
            green = blk_ff.ipal1[ii1];
            blue  = blk_ff.ipal1[ii1];
            alpha = blk_ff.ipal2[ii2];
         end
         default: begin
            if (blk_ff.three && (ci == 2'd3)) begin
               alpha = 8'h00;
            end
         end
      endcase
   end

   always_comb begin
      busy_in  = busy_ff;
      count_in = count_ff;
      if (take) begin
         busy_in  = in_valid;
         count_in = 4'd0;
      end else if (fire) begin
         count_in = count_ff + 4'd1;
      end
   end

   assign out_valid_in = out_load ? busy_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         count_ff     <= 4'd0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         blk_ff <= in_data;
      end
      if (fire) begin
         out_data_ff <= {4'b0000, alpha, blue, green, red, count_ff};
         out_last_ff <= (count_ff == 4'd15);
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

// ===== design/bcn_texture_block_decoder.sv =====
// ----------------------------------------------------------------------------
// bcn_texture_block_decoder
// BC1..BC5 compressed 4x4 block decoder with RGBA8 texel output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// Each accepted block produces sixteen texels, in row-major order, on the
// result channel, one texel per cycle while rsp_tready is high; the block
// rate is set by the texel serializer in front of the result register.
// The first texel of a block passes the input, numerator, palette and
// serializer registers before the result register. Three blocks can wait
// in the input, numerator and palette stages behind the serializer, so
// req_tready can stay high while earlier blocks are still being delivered,
// until those stages are full. The format register is written through the
// csr channel, which is always ready; it must be written only while no
// block is in flight. Codes five through seven decode as BC1.

module bcn_texture_block_decoder
   import bcn_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_data,
   input  logic         req_tvalid,
   output logic         req_tready,
   // [63:0] color or first channel block, [127:64] alpha or second channel block
   input  logic [127:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [3:0] texel_index, [11:4] red, [19:12] green, [27:20] blue,
   // [35:28] alpha, [39:36] zero
   output logic [39:0]  rsp_tdata,
   output logic         rsp_tlast
);

   logic [2:0] format_ff;
   logic       s1_valid_ff, s1_valid_in;
   blk_type    s1_data_ff, s1_data_in;
   logic       s1_load, s2_load, s3_load;
   logic       s2_valid, s3_valid, ser_take;
   num_type    s2_data;
   pal_type    s3_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         format_ff <= 3'd0;
      end else if (csr_valid && csr_ready) begin
         format_ff <= csr_data;
      end
   end

   // Each stage loads when it is empty or its content moves on.
   assign s3_load = !s3_valid || ser_take;
   assign s2_load = !s2_valid || s3_load;
   assign s1_load = !s1_valid_ff || s2_load;
   assign req_tready = s1_load;

   always_comb begin
      s1_data_in.cb = req_tdata[63:0];
      s1_data_in.ab = req_tdata[127:64];
      unique case (format_ff)
         FMT_BC2: s1_data_in.fmt = FMT_BC2;
         FMT_BC3: s1_data_in.fmt = FMT_BC3;
         FMT_BC4: s1_data_in.fmt = FMT_BC4;
         FMT_BC5: s1_data_in.fmt = FMT_BC5;
         default: s1_data_in.fmt = FMT_BC1;
      endcase
   end

   assign s1_valid_in = s1_load ? req_tvalid : s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_data_ff <= s1_data_in;
      end
   end

   bcn_numer u_numer (
      .clock     (clock),
      .reset     (reset),
      .load      (s2_load),
      .in_valid  (s1_valid_ff),
      .in_data   (s1_data_ff),
      .out_valid (s2_valid),
      .out_data  (s2_data)
   );

   bcn_recip u_recip (
      .clock     (clock),
      .reset     (reset),
      .load      (s3_load),
      .in_valid  (s2_valid),
      .in_data   (s2_data),
      .out_valid (s3_valid),
      .out_data  (s3_data)
   );

   bcn_serial u_serial (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (s3_valid),
      .in_data    (s3_data),
      .take       (ser_take),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== design/bcn_checker.sv =====
// ----------------------------------------------------------------------------
// bcn_checker
// Port-level checks on the result channel of the texture block decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "bcn_texture_block_decoder_assert.svh"

module bcn_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic        rsp_tlast
);

   // A stalled transaction keeps its payload.
   `BCN_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "result changed while stalled")

   // The last flag marks exactly the sixteenth texel.
   `BCN_ASSERT(a_last_index, clock, reset, rsp_tvalid |-> (rsp_tlast == (rsp_tdata[3:0] == 4'd15)), "last flag does not match texel index")

   // Inside a block the texels follow each other without a gap.
   `BCN_ASSERT(a_index_step, clock, reset, rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid && (rsp_tdata[3:0] == $past(rsp_tdata[3:0]) + 4'd1), "texel sequence broken")

   // Nothing is offered right after reset.
   `BCN_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_tvalid, "result valid after reset")

endmodule

bind bcn_texture_block_decoder bcn_checker u_checker (.*);

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Checks the BC1..BC5 texture block decoder texel by texel. Every accepted
// block is decoded by a predictor in the bench, and each texel that leaves the
// result stream is compared with the oldest predicted texel. Directed blocks
// cover palette modes and extremes of each format, then random traffic runs
// under several idle and stall profiles, after a long receiver hold-off test.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
   import bcn_pkg::*;

   localparam logic [2:0] FMT_SPARE5 = 3'd5;
   localparam logic [2:0] FMT_SPARE6 = 3'd6;
   localparam logic [2:0] FMT_SPARE7 = 3'd7;

   localparam int unsigned SETTLE_CYCLES = 12;
   localparam int unsigned HOLD_CYCLES   = 240;
   localparam int unsigned SEG_ITEMS     = 17;

   // Interpolated index patterns that walk every ramp entry, and colour
   // indices that walk all four palette entries.
   localparam logic [47:0] RAMP_WALK  = 48'o76543210_76543210;
   localparam logic [31:0] COLOR_WALK = 32'hE4E4E4E4;

   typedef struct packed {
      logic [3:0] pad;
      logic [7:0] alpha;
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
      logic [3:0] index;
      logic       last;
   } texel_type;

   logic         clock;
   logic         reset;
   logic         csr_valid;
   logic         csr_ready;
   logic [2:0]   csr_data;
   logic         req_tvalid;
   logic         req_tready;
   logic [127:0] req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [39:0]  rsp_tdata;
   logic         rsp_tlast;

   texel_type    texels_due[$];
   logic [2:0]   active_format;
   int unsigned  send_idle_pct;
   int unsigned  recv_stall_pct;
   int unsigned  mismatch_count;
   bit           long_hold_go;
   int unsigned  hold_left;

   bcn_texture_block_decoder dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("status: fail");
      $finish;
   end

   // ---------------------------------------------------------------- predictor

   function automatic logic [7:0] endpoint_mix(input int unsigned e0, e1, w0, w1,
                                               den, maxv);
      return 8'(((w0 * e0 + w1 * e1) * 255) / (den * maxv));
   endfunction

   function automatic void build_ramp(input logic [63:0] blk, output logic [7:0] ramp[8]);
      int unsigned a0, a1;
      a0 = 32'(blk[7:0]);
      a1 = 32'(blk[15:8]);
      ramp[0] = 8'(a0);
      ramp[1] = 8'(a1);
      if (a0 > a1) begin
         for (int k = 1; k <= 6; k++) ramp[k + 1] = 8'(((7 - k) * a0 + k * a1) / 7);
      end else begin
         for (int k = 1; k <= 4; k++) ramp[k + 1] = 8'(((5 - k) * a0 + k * a1) / 5);
         ramp[6] = 8'd0;
         ramp[7] = 8'd255;
      end
   endfunction

   function automatic void predict_texels(input logic [2:0] code, input logic [63:0] cb,
                                          input logic [63:0] ab);
      fmt_type      f;
      logic [7:0]   cpal[4][4];
      logic [7:0]   ramp1[8];
      logic [7:0]   ramp2[8];
      int unsigned  e0[3], e1[3], mx[3];
      logic [15:0]  c0, c1;
      bit           three;
      logic [1:0]   ci;
      texel_type    tx;
      f  = (code > 3'd4) ? FMT_BC1 : fmt_type'(code);
      c0 = cb[15:0];
      c1 = cb[31:16];
      three = (f == FMT_BC1) && (c0 <= c1);
      e0[0] = 32'(c0[15:11]); e0[1] = 32'(c0[10:5]); e0[2] = 32'(c0[4:0]);
      e1[0] = 32'(c1[15:11]); e1[1] = 32'(c1[10:5]); e1[2] = 32'(c1[4:0]);
      mx[0] = 31; mx[1] = 63; mx[2] = 31;
      for (int ch = 0; ch < 3; ch++) begin
         cpal[0][ch] = endpoint_mix(e0[ch], e1[ch], 1, 0, 1, mx[ch]);
         cpal[1][ch] = endpoint_mix(e0[ch], e1[ch], 0, 1, 1, mx[ch]);
         if (three) begin
            cpal[2][ch] = endpoint_mix(e0[ch], e1[ch], 1, 1, 2, mx[ch]);
            cpal[3][ch] = 8'd0;
         end else begin
            cpal[2][ch] = endpoint_mix(e0[ch], e1[ch], 2, 1, 3, mx[ch]);
            cpal[3][ch] = endpoint_mix(e0[ch], e1[ch], 1, 2, 3, mx[ch]);
         end
      end
      cpal[0][3] = 8'd255;
      cpal[1][3] = 8'd255;
      cpal[2][3] = 8'd255;
      cpal[3][3] = three ? 8'd0 : 8'd255;
      build_ramp(cb, ramp1);
      build_ramp(ab, ramp2);

      for (int t = 0; t < 16; t++) begin
         tx.pad   = 4'd0;
         tx.index = 4'(t);
         tx.last  = (t == 15);
         if (f == FMT_BC1 || f == FMT_BC2 || f == FMT_BC3) begin
            ci = cb[32 + 2 * t +: 2];
            tx.red   = cpal[ci][0];
            tx.green = cpal[ci][1];
            tx.blue  = cpal[ci][2];
            tx.alpha = cpal[ci][3];
            if (f == FMT_BC2) tx.alpha = 8'(ab[4 * t +: 4] * 17);
            else if (f == FMT_BC3) tx.alpha = ramp2[ab[16 + 3 * t +: 3]];
         end else begin
            tx.red   = ramp1[cb[16 + 3 * t +: 3]];
            tx.green = tx.red;
            tx.blue  = tx.red;
            tx.alpha = (f == FMT_BC5) ? ramp2[ab[16 + 3 * t +: 3]] : tx.red;
         end
         texels_due.push_back(tx);
      end
   endfunction

   // ------------------------------------------------------------ stimulus side

   task automatic send_block(input logic [63:0] cb, input logic [63:0] ab);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {ab, cb};
      do @(posedge clock); while (!req_tready);
      predict_texels(active_format, cb, ab);
   endtask

   // Lowers the request, waits for every predicted texel, then lets the
   // pipeline settle.
   task automatic drain_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (texels_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_format(input logic [2:0] code);
      drain_results();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= code;
      do @(posedge clock); while (!csr_ready);
      active_format = code;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [127:0] random_block();
      logic [63:0] cb, ab;
      cb = {$urandom, $urandom};
      ab = {$urandom, $urandom};
      case ($urandom_range(9))
         0: cb[31:16] = cb[15:0];
         1: cb[15:8]  = cb[7:0];
         2: ab[15:8]  = ab[7:0];
         3: cb[31:0]  = {16'h0000, 16'hFFFF};
         4: begin
            cb[15:0] = 16'h00FF;
            ab[15:0] = 16'hFF00;
         end
         default: ;
      endcase
      return {ab, cb};
   endfunction

   // ------------------------------------------------------------ result side

   always @(negedge clock) begin
      if (long_hold_go) begin
         long_hold_go = 1'b0;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      texel_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tdata, rsp_tlast};
         if (texels_due.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("%0t: unexpected texel %h last %b", $realtime, rsp_tdata, rsp_tlast);
         end else begin
            want = texels_due.pop_front();
            if (got.index !== want.index || got.red !== want.red ||
                got.green !== want.green || got.blue !== want.blue ||
                got.alpha !== want.alpha || got.pad !== want.pad ||
                got.last !== want.last) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: texel mismatch exp idx %0d rgba %h %h %h %h pad %h last %b, got idx %0d rgba %h %h %h %h pad %h last %b",
                     $realtime, want.index, want.red, want.green, want.blue, want.alpha,
                     want.pad, want.last, got.index, got.red, got.green, got.blue,
                     got.alpha, got.pad, got.last);
            end
         end
      end
   end

   // --------------------------------------------------------------- the tests

   task automatic test_bc1_palettes();
      write_format(FMT_BC1);
      send_block({COLOR_WALK, 16'h1234, 16'hF81F}, 64'h0);
      send_block({COLOR_WALK, 16'hFFE0, 16'h07FF}, {$urandom, $urandom});
      send_block({COLOR_WALK, 16'h8410, 16'h8410}, 64'h0);
      send_block(64'h0, 64'h0);
      send_block(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
   endtask

   task automatic test_bc2_explicit_alpha();
      write_format(FMT_BC2);
      send_block({COLOR_WALK, 16'hFFFF, 16'h0000}, 64'hFEDC_BA98_7654_3210);
      send_block(64'h0, 64'h0);
      send_block(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
   endtask

   task automatic test_bc3_interp_alpha();
      write_format(FMT_BC3);
      send_block({COLOR_WALK, 16'hF800, 16'h07E0}, {RAMP_WALK, 8'h20, 8'hF0});
      send_block({COLOR_WALK, 16'h001F, 16'hF800}, {RAMP_WALK, 8'hC8, 8'h13});
      send_block({COLOR_WALK, 16'h7BEF, 16'h7BEF}, {RAMP_WALK, 8'h80, 8'h80});
      send_block(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
   endtask

   task automatic test_bc4_single_channel();
      write_format(FMT_BC4);
      send_block({RAMP_WALK, 8'h10, 8'hFF}, {$urandom, $urandom});
      send_block({RAMP_WALK, 8'hFF, 8'h00}, 64'h0);
      send_block({RAMP_WALK, 8'h55, 8'h55}, 64'h0);
   endtask

   task automatic test_bc5_two_channel();
      write_format(FMT_BC5);
      send_block({RAMP_WALK, 8'h00, 8'hFF}, {RAMP_WALK, 8'hFF, 8'h00});
      send_block({RAMP_WALK, 8'h3C, 8'hA5}, {RAMP_WALK, 8'h07, 8'h07});
      send_block(64'hFFFF_FFFF_FFFF_FFFF, 64'h0);
   endtask

   // Codes past BC5 fall back to BC1 decoding.
   task automatic test_spare_format_codes();
      write_format(FMT_SPARE5);
      send_block({COLOR_WALK, 16'hABCD, 16'h1234}, {$urandom, $urandom});
      write_format(FMT_SPARE6);
      send_block({COLOR_WALK, 16'h1234, 16'hABCD}, {$urandom, $urandom});
      write_format(FMT_SPARE7);
      send_block({COLOR_WALK, 16'h5555, 16'h5555}, 64'hFFFF_FFFF_FFFF_FFFF);
   endtask

   task automatic test_random_traffic();
      logic [2:0]   seg_fmt[12];
      int unsigned  idle_profile[4][2];
      logic [127:0] blk;
      seg_fmt = '{FMT_BC1, FMT_BC2, FMT_BC3, FMT_BC4, FMT_BC5, FMT_SPARE5,
                  FMT_BC3, FMT_SPARE6, FMT_BC1, FMT_SPARE7, FMT_BC5, FMT_BC2};
      idle_profile = '{'{0, 0}, '{83, 0}, '{0, 83}, '{6, 6}};
      for (int p = 0; p < 4; p++) begin
         for (int s = 0; s < 3; s++) begin
            write_format(seg_fmt[p * 3 + s]);
            send_idle_pct  = idle_profile[p][0];
            recv_stall_pct = idle_profile[p][1];
            for (int i = 0; i < SEG_ITEMS; i++) begin
               blk = random_block();
               send_block(blk[63:0], blk[127:64]);
            end
         end
      end
   endtask

   // The receiver holds off long enough for the pipeline to fill and push back
   // on the request side, while blocks keep being offered.
   task automatic test_backpressure();
      logic [127:0] blk;
      write_format(FMT_BC5);
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      long_hold_go   = 1'b1;
      for (int i = 0; i < 10; i++) begin
         blk = random_block();
         send_block(blk[63:0], blk[127:64]);
      end
      drain_results();
   endtask

   initial begin
      reset          = 1'b1;
      csr_valid      = 1'b0;
      csr_data       = 3'd0;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      active_format  = FMT_BC1;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      mismatch_count = 0;
      long_hold_go   = 1'b0;
      hold_left      = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_bc1_palettes();
      test_bc2_explicit_alpha();
      test_bc3_interp_alpha();
      test_bc4_single_channel();
      test_bc5_two_channel();
      test_spare_format_codes();
      test_backpressure();
      test_random_traffic();
      drain_results();

      if (mismatch_count == 0 && texels_due.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ===== bcn_texture_block_decoder.f =====
+incdir+design
design/bcn_pkg.sv
design/bcn_numer.sv
design/bcn_recip.sv
design/bcn_serial.sv
design/bcn_texture_block_decoder.sv
design/bcn_checker.sv
tb/testbench.sv
